>>> rtl/core/lcc_pkg.sv
// Shared types and constants of the link congestion cost monitor.
`timescale 1ns / 1ps
package lcc_pkg;

  // Defaults of the top-level parameters.
  localparam int PORTS_DEF  = 8;
  localparam int WINDOW_DEF = 10;
  localparam int BANDS_DEF  = 4;

  // Field widths.
  localparam int PORT_W  = 3;
  localparam int COUNT_W = 64;
  localparam int DELTA_W = 32;
  localparam int SUM_W   = 36;
  localparam int SLOT_W  = 4;
  localparam int COST_W  = 16;
  localparam int BAND_W  = 2;
  localparam int LIM_W   = 8;
  localparam int CAP_W   = 32;
  localparam int WGT_W   = 16;
  localparam int BASE_W  = 8;
  localparam int LIMS_W  = 16;

  // Shared divider widths.
  localparam int DIV_W  = 50;
  localparam int DEN_W  = 32;
  localparam int USED_W = 35;

  // Reciprocal multiply for the divides by the window length: the reciprocal
  // is scaled by 2^REC_K and applied in two halves of REC_H bits.
  localparam int REC_K = 40;
  localparam int REC_H = 20;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND3    = 3'd6;

  localparam logic [CAP_W-1:0]  CAP_RST   = 32'd10000000;
  localparam logic [WGT_W-1:0]  WGT_RST   = 16'd500;
  localparam logic [BASE_W-1:0] BASE_RST  = 8'd10;
  localparam logic [LIMS_W-1:0] BAND0_RST = 16'd10240;
  localparam logic [LIMS_W-1:0] BAND1_RST = 16'd16670;
  localparam logic [LIMS_W-1:0] BAND2_RST = 16'd23095;
  localparam logic [LIMS_W-1:0] BAND3_RST = 16'd28240;

  typedef enum logic [1:0] {
    REP_NONE = 2'd0,
    REP_DOWN = 2'd1,
    REP_UP   = 2'd2
  } report_e;

  // One per-port state word.
  typedef struct packed {
    logic [COUNT_W-1:0] last;
    logic [SUM_W-1:0]   sum;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  fill;
    logic [BAND_W-1:0]  band;
  } port_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/core/lcc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lcc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcc_pkg::div_req_t req_i,
  output lcc_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(lcc_pkg::DIV_W + 1);

  logic [lcc_pkg::DIV_W-1:0] quo_q, quo_d;
  logic [lcc_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [lcc_pkg::DEN_W-1:0] den_q;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [lcc_pkg::DEN_W:0]   trial;
  logic                      ge;

  always_comb begin
    trial  = {rem_q, quo_q[lcc_pkg::DIV_W-1]};
    ge     = trial >= {1'b0, den_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      cnt_d  = CNT_W'(lcc_pkg::DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? lcc_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[lcc_pkg::DEN_W-1:0];
      quo_d = {quo_q[lcc_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      den_q <= req_i.den;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> rtl/core/link_congestion_cost_monitor_top.sv
// Top level of the link congestion cost monitor: sequencer, state memories, config.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | sink      | in_valid_i / in_stall_o   | port_i, tx_byte_count_i
//  out     | source    | out_valid_o / out_stall_i | out_port_o, warming_up_o, link_cost_o,
//          |           |                           | band_o, report_o
//  cfg     | sink      | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item at a time. An out-of-range item goes from idle straight to the done state,
// a warm-up item through the read states RD1 and RD2. An evaluated item continues with
// two reciprocal multiplies, each in REC_LO and REC_HI, for the average and the utilization,
// then the bit-serial divider by the link capacity for the cost quotient. The result is
// loaded into the output register from the done state; the sequencer then returns to idle to accept the next item.
// Reset clears the per-port valid bits; an invalid port entry reads as all zero. The
// window memory needs no clearing: an old slot is used only after the port wrote it.
// A stalled result stays in the output register while the next item is accepted; that
// item holds in its final state until the output register frees up.
`timescale 1ns / 1ps
module link_congestion_cost_monitor_top #(
  parameter int PORTS  = lcc_pkg::PORTS_DEF,
  parameter int WINDOW = lcc_pkg::WINDOW_DEF,
  parameter int BANDS  = lcc_pkg::BANDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lcc_pkg::PORT_W-1:0]    port_i,
  input  logic [lcc_pkg::COUNT_W-1:0]   tx_byte_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lcc_pkg::PORT_W-1:0]    out_port_o,
  output logic                          warming_up_o,
  output logic [lcc_pkg::COST_W-1:0]    link_cost_o,
  output logic [lcc_pkg::BAND_W-1:0]    band_o,
  output logic [1:0]                    report_o,
  input  logic                          cfg_we_i,
  input  logic [lcc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lcc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int PA_W   = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int WDEPTH = PORTS * WINDOW;
  localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int C_W    = lcc_pkg::DIV_W + 1;

  // Reciprocal of the window length, ceil(2^REC_K / WINDOW), split into two halves.
  localparam int REC_P_W = lcc_pkg::SUM_W + lcc_pkg::REC_H;
  localparam int REC_A_W = lcc_pkg::SUM_W + lcc_pkg::REC_K;
  localparam logic [lcc_pkg::REC_K-1:0] REC_M =
    lcc_pkg::REC_K'(((64'd1 << lcc_pkg::REC_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic [lcc_pkg::REC_H-1:0] REC_ML = REC_M[lcc_pkg::REC_H-1:0];
  localparam logic [lcc_pkg::REC_K-lcc_pkg::REC_H-1:0] REC_MH =
    REC_M[lcc_pkg::REC_K-1:lcc_pkg::REC_H];

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RD1      = 3'd1;
  localparam logic [2:0] ST_RD2      = 3'd2;
  localparam logic [2:0] ST_REC_LO   = 3'd3;
  localparam logic [2:0] ST_REC_HI   = 3'd4;
  localparam logic [2:0] ST_MUL      = 3'd5;
  localparam logic [2:0] ST_DIV_COST = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  // ---------------------------------------------------------------- config registers
  logic [lcc_pkg::CAP_W-1:0]  cap_q;
  logic [lcc_pkg::WGT_W-1:0]  weight_q;
  logic [lcc_pkg::BASE_W-1:0] base_q;
  logic [lcc_pkg::LIMS_W-1:0] lims_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= lcc_pkg::CAP_RST;
      weight_q <= lcc_pkg::WGT_RST;
      base_q   <= lcc_pkg::BASE_RST;
      lims_q[0] <= lcc_pkg::BAND0_RST;
      lims_q[1] <= lcc_pkg::BAND1_RST;
      lims_q[2] <= lcc_pkg::BAND2_RST;
      lims_q[3] <= lcc_pkg::BAND3_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lcc_pkg::CFG_CAPACITY: cap_q    <= cfg_wdata_i;
        lcc_pkg::CFG_WEIGHT:   weight_q <= cfg_wdata_i[lcc_pkg::WGT_W-1:0];
        lcc_pkg::CFG_BASE:     base_q   <= cfg_wdata_i[lcc_pkg::BASE_W-1:0];
        lcc_pkg::CFG_BAND0:    lims_q[0] <= cfg_wdata_i[lcc_pkg::LIMS_W-1:0];
        lcc_pkg::CFG_BAND1:    lims_q[1] <= cfg_wdata_i[lcc_pkg::LIMS_W-1:0];
        lcc_pkg::CFG_BAND2:    lims_q[2] <= cfg_wdata_i[lcc_pkg::LIMS_W-1:0];
        lcc_pkg::CFG_BAND3:    lims_q[3] <= cfg_wdata_i[lcc_pkg::LIMS_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer state
  logic [2:0]                  st_q, st_d;
  logic [lcc_pkg::PORT_W-1:0]  port_q;
  logic [lcc_pkg::COUNT_W-1:0] tx_q;
  logic                        oor_q, oor_d;
  logic                        warm_q, warm_d;
  lcc_pkg::port_state_t        cur_q, cur_d;
  logic [lcc_pkg::DELTA_W-1:0] delta_q, delta_d;
  logic [WA_W-1:0]             waddr_q, waddr_d;
  logic [lcc_pkg::SUM_W-1:0]   rx_q, rx_d;
  logic [REC_P_W-1:0]          rlo_q, rlo_d;
  logic                        rph_q, rph_d;
  logic [lcc_pkg::USED_W-1:0]  used_q, used_d;
  logic [lcc_pkg::COST_W-1:0]  cost_q, cost_d;
  logic [lcc_pkg::BAND_W-1:0]  nband_q, nband_d;
  lcc_pkg::report_e            rep_q, rep_d;

  logic accept;
  logic finish;
  assign in_stall_o = (st_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign finish     = (st_q == ST_DONE) && (!out_valid_o || !out_stall_i);

  // ---------------------------------------------------------------- per-port state memory
  lcc_pkg::port_state_t smem [PORTS];
  lcc_pkg::port_state_t srd_q;
  logic [PORTS-1:0]     svalid_q;
  logic                 srd_valid_q;
  logic [PA_W-1:0]      sr_addr, sw_addr;
  lcc_pkg::port_state_t swdata;

  assign sr_addr = PA_W'(port_i);
  assign sw_addr = PA_W'(port_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      srd_q <= smem[sr_addr];
    end
    if (finish && !oor_q) begin
      smem[sw_addr] <= swdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svalid_q    <= '0;
      srd_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        srd_valid_q <= svalid_q[sr_addr];
      end
      if (finish && !oor_q) begin
        svalid_q[sw_addr] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- delta window memory
  logic [lcc_pkg::DELTA_W-1:0] wmem [WDEPTH];
  logic [lcc_pkg::DELTA_W-1:0] wrd_q;
  logic                        wrd_en, wwr_en;

  always_ff @(posedge clk_i) begin
    if (wrd_en) begin
      wrd_q <= wmem[waddr_d];
    end
    if (wwr_en) begin
      wmem[waddr_q] <= delta_q;
    end
  end

  // ---------------------------------------------------------------- shared divider
  lcc_pkg::div_req_t div_req;
  lcc_pkg::div_rsp_t div_rsp;

  lcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- datapath
  lcc_pkg::port_state_t        rd_state;
  logic [lcc_pkg::COUNT_W-1:0] diff;
  logic [lcc_pkg::SLOT_W-1:0]  slot_eff, slot_nxt;
  logic                        filling;
  logic [lcc_pkg::DELTA_W-1:0] old_delta;
  logic [lcc_pkg::SUM_W-1:0]   new_sum;
  logic [REC_P_W-1:0]          rec_lo, rec_hi;
  logic [REC_A_W-1:0]          rec_acc;
  logic [lcc_pkg::SUM_W-1:0]   rec_q;
  logic [C_W-1:0]              prod;
  logic [C_W-1:0]              cost_full;
  logic [lcc_pkg::LIMS_W-1:0]  lim;
  logic [lcc_pkg::LIM_W-1:0]   lower, upper;
  logic                        go_down, go_up;
  logic [lcc_pkg::DEN_W-1:0]   cap_eff;

  assign rd_state  = srd_valid_q ? srd_q : '0;
  assign diff      = tx_q - rd_state.last;
  assign slot_eff  = (cur_q.slot >= lcc_pkg::SLOT_W'(WINDOW)) ? '0 : cur_q.slot;
  assign slot_nxt  = (slot_eff + 1'b1 >= lcc_pkg::SLOT_W'(WINDOW)) ? '0 : slot_eff + 1'b1;
  assign filling   = cur_q.fill < lcc_pkg::SLOT_W'(WINDOW);
  // While filling, the slot about to be replaced was never written: treat it as zero.
  assign old_delta = filling ? '0 : wrd_q;
  assign new_sum   = cur_q.sum - lcc_pkg::SUM_W'(old_delta) + lcc_pkg::SUM_W'(delta_q);
  // floor(x / WINDOW) = (x * REC_M) >> REC_K, exact for x below WINDOW * 2^32.
  assign rec_lo    = REC_P_W'(rx_q) * REC_P_W'(REC_ML);
  assign rec_hi    = REC_P_W'(rx_q) * REC_P_W'(REC_MH);
  assign rec_acc   = REC_A_W'(rlo_q) + {rec_hi, {lcc_pkg::REC_H{1'b0}}};
  assign rec_q     = rec_acc[REC_A_W-1:lcc_pkg::REC_K];
  assign prod      = C_W'(weight_q) * C_W'(used_q);
  assign cap_eff   = (cap_q == '0) ? lcc_pkg::DEN_W'(1) : cap_q;
  assign cost_full = C_W'(base_q) + C_W'(div_rsp.quo);
  assign lim       = lims_q[cur_q.band];
  assign upper     = lim[lcc_pkg::LIMS_W-1:lcc_pkg::LIM_W];
  assign lower     = lim[lcc_pkg::LIM_W-1:0];
  // cost*cap = (base + q)*cap + r with r < cap, so compare the integer part and
  // break a tie at the upper threshold on a nonzero remainder.
  assign go_down   = cost_full < C_W'(lower);
  assign go_up     = !go_down && ((cost_full > C_W'(upper)) ||
                     ((cost_full == C_W'(upper)) && (div_rsp.rem != '0)));

  always_comb begin
    swdata      = cur_q;
    swdata.last = tx_q;
    swdata.slot = slot_nxt;
    swdata.fill = warm_q ? cur_q.fill + 1'b1 : cur_q.fill;
    swdata.band = nband_q;
  end

  always_comb begin
    st_d     = st_q;
    oor_d    = oor_q;
    warm_d   = warm_q;
    cur_d    = cur_q;
    delta_d  = delta_q;
    waddr_d  = waddr_q;
    rx_d     = rx_q;
    rlo_d    = rlo_q;
    rph_d    = rph_q;
    used_d   = used_q;
    cost_d   = cost_q;
    nband_d  = nband_q;
    rep_d    = rep_q;
    wrd_en   = 1'b0;
    wwr_en   = 1'b0;
    div_req  = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          oor_d  = int'(port_i) >= PORTS;
          warm_d = 1'b1;
          cost_d = '0;
          rep_d  = lcc_pkg::REP_NONE;
          st_d   = (int'(port_i) >= PORTS) ? ST_DONE : ST_RD1;
        end
      end
      ST_RD1: begin
        // Latch the port state, form the saturated delta and fetch the old slot.
        cur_d   = rd_state;
        delta_d = (diff[lcc_pkg::COUNT_W-1:lcc_pkg::DELTA_W] != '0) ? '1
                                                                   : diff[lcc_pkg::DELTA_W-1:0];
        waddr_d = WA_W'(int'(sw_addr) * WINDOW +
                  ((rd_state.slot >= lcc_pkg::SLOT_W'(WINDOW)) ? 0 : int'(rd_state.slot)));
        wrd_en  = 1'b1;
        st_d    = ST_RD2;
      end
      ST_RD2: begin
        wwr_en    = 1'b1;
        cur_d.sum = new_sum;
        nband_d   = cur_q.band;
        if (filling) begin
          warm_d = 1'b1;
          st_d   = ST_DONE;
        end else begin
          warm_d = 1'b0;
          rx_d   = new_sum;
          rph_d  = 1'b0;
          st_d   = ST_REC_LO;
        end
      end
      ST_REC_LO: begin
        rlo_d = rec_lo;
        st_d  = ST_REC_HI;
      end
      ST_REC_HI: begin
        if (!rph_q) begin
          // Average is below 2^32: scale it by 8 for the utilization divide.
          rx_d  = {rec_q[lcc_pkg::SUM_W-4:0], 3'b000};
          rph_d = 1'b1;
          st_d  = ST_REC_LO;
        end else begin
          used_d = rec_q[lcc_pkg::USED_W-1:0];
          st_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        div_req.start = 1'b1;
        div_req.num   = prod[lcc_pkg::DIV_W-1:0];
        div_req.den   = cap_eff;
        st_d          = ST_DIV_COST;
      end
      ST_DIV_COST: begin
        if (div_rsp.done) begin
          cost_d = (cost_full > C_W'({lcc_pkg::COST_W{1'b1}})) ? '1
                                                               : cost_full[lcc_pkg::COST_W-1:0];
          if (go_down && cur_q.band != '0) begin
            nband_d = cur_q.band - 1'b1;
            rep_d   = lcc_pkg::REP_DOWN;
          end else if (go_up && (int'(cur_q.band) + 1 < BANDS)) begin
            nband_d = cur_q.band + 1'b1;
            rep_d   = lcc_pkg::REP_UP;
          end
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      port_q <= port_i;
      tx_q   <= tx_byte_count_i;
    end
    oor_q   <= oor_d;
    warm_q  <= warm_d;
    cur_q   <= cur_d;
    delta_q <= delta_d;
    waddr_q <= waddr_d;
    rx_q    <= rx_d;
    rlo_q   <= rlo_d;
    rph_q   <= rph_d;
    used_q  <= used_d;
    cost_q  <= cost_d;
    nband_q <= nband_d;
    rep_q   <= rep_d;
  end

  // ---------------------------------------------------------------- output register
  logic                        out_valid_q;
  logic [lcc_pkg::PORT_W-1:0]  out_port_q;
  logic                        out_warm_q;
  logic [lcc_pkg::COST_W-1:0]  out_cost_q;
  logic [lcc_pkg::BAND_W-1:0]  out_band_q;
  logic [1:0]                  out_rep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_port_q <= port_q;
      out_warm_q <= oor_q || warm_q;
      out_cost_q <= oor_q ? '0 : cost_q;
      out_band_q <= oor_q ? '0 : nband_q;
      out_rep_q  <= oor_q ? lcc_pkg::REP_NONE : rep_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_port_o   = out_port_q;
  assign warming_up_o = out_warm_q;
  assign link_cost_o  = out_cost_q;
  assign band_o       = out_band_q;
  assign report_o     = out_rep_q;

`ifndef NO_ASSERTIONS
  a_warm_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && warming_up_o |-> report_o == lcc_pkg::REP_NONE && link_cost_o == '0)
    else $error("warm-up item carries a cost or report");
  a_up_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_o == lcc_pkg::REP_UP |-> band_o != '0)
    else $error("step up reported at band zero");
  a_down_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_o == lcc_pkg::REP_DOWN |-> int'(band_o) < BANDS - 1)
    else $error("step down reported at top band");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> st_q == ST_DIV_COST)
    else $error("divider finished outside the cost divide step");
`endif

endmodule

>>> bench/link_congestion_cost_monitor_top_tb.sv
// Self-checking testbench of the link congestion cost monitor top level.
`timescale 1ns / 1ps
module link_congestion_cost_monitor_top_tb;

  localparam int NPORT   = 8;
  localparam int NWIN    = 10;
  localparam int NBAND   = 4;
  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    logic [lcc_pkg::PORT_W-1:0] port;
    logic                       warm;
    logic [lcc_pkg::COST_W-1:0] cost;
    logic [lcc_pkg::BAND_W-1:0] band;
    lcc_pkg::report_e           rep;
  } cost_rec_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [lcc_pkg::PORT_W-1:0]     port_i = '0;
  logic [lcc_pkg::COUNT_W-1:0]    tx_byte_count_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [lcc_pkg::PORT_W-1:0]     out_port_o;
  logic                           warming_up_o;
  logic [lcc_pkg::COST_W-1:0]     link_cost_o;
  logic [lcc_pkg::BAND_W-1:0]     band_o;
  logic [1:0]                     report_o;
  logic                           cfg_we_i = 1'b0;
  logic [lcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [lcc_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  link_congestion_cost_monitor_top dut (.*);

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the block's configuration and per-port state.
  logic [31:0] capacity;
  logic [15:0] weight;
  logic [7:0]  base;
  logic [15:0] band_lims [NBAND];
  logic [63:0] last_cnt  [NPORT];
  logic [31:0] deltas    [NPORT][NWIN];
  logic [63:0] delta_sum [NPORT];
  int          slot_ptr  [NPORT];
  int          fill_cnt  [NPORT];
  int          cur_band  [NPORT];

  cost_rec_t pending_costs[$];
  int        errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_evals = 0;
  int        n_moves = 0;
  bit        no_gaps = 0;
  int        quiet = 0;
  int        stall_left = 0;
  logic [63:0] walk_lvl [NPORT];

  // Model one accepted sample and queue the expected result.
  function automatic void predict_cost(logic [lcc_pkg::PORT_W-1:0] p, logic [63:0] tx);
    cost_rec_t   r;
    logic [63:0] d, avg, used, cap, num, scaled, cint, lo, hi;
    int          b;
    d = tx - last_cnt[p];
    if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
    last_cnt[p] = tx;
    delta_sum[p] = delta_sum[p] - deltas[p][slot_ptr[p]] + d;
    deltas[p][slot_ptr[p]] = d[31:0];
    slot_ptr[p] = (slot_ptr[p] + 1) % NWIN;
    b = cur_band[p];
    r.port = p;
    r.rep  = lcc_pkg::REP_NONE;
    if (fill_cnt[p] < NWIN) begin
      fill_cnt[p]++;
      r.warm = 1'b1;
      r.cost = '0;
      r.band = b[1:0];
    end else begin
      avg    = delta_sum[p] / NWIN;
      used   = (avg * 8) / NWIN;
      cap    = (capacity == 0) ? 64'd1 : {32'd0, capacity};
      num    = weight * used;
      scaled = base * cap + num;
      cint   = base + num / cap;
      if (cint > 65535) cint = 65535;
      lo = band_lims[b][7:0];
      hi = band_lims[b][15:8];
      if (scaled < lo * cap) begin
        if (b > 0) begin
          b--;
          r.rep = lcc_pkg::REP_DOWN;
        end
      end else if (scaled > hi * cap) begin
        if (b < NBAND - 1) begin
          b++;
          r.rep = lcc_pkg::REP_UP;
        end
      end
      cur_band[p] = b;
      r.warm = 1'b0;
      r.cost = cint[15:0];
      r.band = b[1:0];
      n_evals++;
      if (r.rep != lcc_pkg::REP_NONE) n_moves++;
    end
    pending_costs.push_back(r);
  endfunction

  // Send one item; valid stays high across back-to-back items.
  task automatic send_sample(logic [lcc_pkg::PORT_W-1:0] p, logic [63:0] tx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    port_i          <= p;
    tx_byte_count_i <= tx;
    do @(posedge clk_i); while (in_stall_o);
    predict_cost(p, tx);
    n_sent++;
  endtask

  // Drain all results, then let the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [lcc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lcc_pkg::CFG_CAPACITY: capacity = val;
      lcc_pkg::CFG_WEIGHT:   weight   = val[15:0];
      lcc_pkg::CFG_BASE:     base     = val[7:0];
      lcc_pkg::CFG_BAND0:    band_lims[0] = val[15:0];
      lcc_pkg::CFG_BAND1:    band_lims[1] = val[15:0];
      lcc_pkg::CFG_BAND2:    band_lims[2] = val[15:0];
      lcc_pkg::CFG_BAND3:    band_lims[3] = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] cap, logic [15:0] wgt, logic [7:0] bc,
                           logic [15:0] l0, logic [15:0] l1, logic [15:0] l2,
                           logic [15:0] l3);
    write_reg(lcc_pkg::CFG_CAPACITY, cap);
    write_reg(lcc_pkg::CFG_WEIGHT, {16'd0, wgt});
    write_reg(lcc_pkg::CFG_BASE, {24'd0, bc});
    write_reg(lcc_pkg::CFG_BAND0, {16'd0, l0});
    write_reg(lcc_pkg::CFG_BAND1, {16'd0, l1});
    write_reg(lcc_pkg::CFG_BAND2, {16'd0, l2});
    write_reg(lcc_pkg::CFG_BAND3, {16'd0, l3});
  endtask

  // Counter wrap, saturated deltas, warm-up, and the first evaluations.
  task automatic test_warmup_and_wrap();
    send_sample(3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(3'd1, 64'd5);
    send_sample(3'd1, 64'd5);
    send_sample(3'd1, 64'h0000_0001_0000_0005);
    for (int i = 0; i < 8; i++)
      send_sample(3'd1, last_cnt[1] + 64'd2_000_000_000);
    send_sample(3'd7, 64'h5555_5555_AAAA_AAAA);
    send_sample(3'd0, 64'd0);
    wait_idle();
  endtask

  // Walk one port up through every band and back down to the bottom.
  task automatic test_band_walk();
    write_all(32'd100, 16'd100, 8'd0, 16'h0A00, 16'h1405, 16'h1E0F, 16'h2819);
    for (int i = 0; i < 14; i++) send_sample(3'd2, last_cnt[2] + 64'd5000);
    for (int i = 0; i < 16; i++) send_sample(3'd2, last_cnt[2]);
    wait_idle();
  endtask

  // Register extremes: zero capacity, top weight and base, empty and full limits.
  task automatic test_reg_extremes();
    write_all(32'd0, 16'hFFFF, 8'hFF, 16'hFFFF, 16'h0000, 16'hFF00, 16'h00FF);
    for (int i = 0; i < 12; i++) send_sample(3'd3, last_cnt[3] + {$urandom, $urandom});
    wait_idle();
    write_all(32'hFFFF_FFFF, 16'd0, 8'd0, 16'h0000, 16'hFFFF, 16'h0101, 16'h8040);
    for (int i = 0; i < 12; i++) send_sample(3'd3, last_cnt[3] + 64'($urandom));
    wait_idle();
  endtask

  // Random counter streams per port under a random setting.
  task automatic test_random_phase(int items);
    logic [lcc_pkg::PORT_W-1:0] p;
    logic [63:0]                tx;
    logic [7:0]                 lo, hi;
    logic [15:0]                lims [NBAND];
    for (int b = 0; b < NBAND; b++) begin
      lo = 8'($urandom_range(0, 120));
      hi = 8'(lo + $urandom_range(0, 100));
      lims[b] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : {hi, lo};
    end
    write_all($urandom >> $urandom_range(0, 31), 16'($urandom), 8'($urandom_range(0, 40)),
              lims[0], lims[1], lims[2], lims[3]);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < items; i++) begin
      p = lcc_pkg::PORT_W'($urandom);
      if ($urandom_range(0, 15) == 0) walk_lvl[p] = 64'($urandom >> $urandom_range(0, 31));
      // Mostly well-formed growth; sometimes a wild counter value.
      if ($urandom_range(0, 39) == 0) tx = {$urandom, $urandom};
      else tx = last_cnt[p] + walk_lvl[p] + (64'($urandom) & (walk_lvl[p] >> 2));
      send_sample(p, tx);
    end
    wait_idle();
  endtask

  // Drive the result stall, and check each result against the oldest expectation.
  always @(posedge clk_i) begin
    cost_rec_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
      else quiet <= quiet + 1;
      if (out_valid_o && !out_stall_i) begin
        n_checked++;
        if (pending_costs.size() == 0) begin
          $display("%0t: unexpected result port=%0d", $realtime, out_port_o);
          errors++;
        end else begin
          e = pending_costs.pop_front();
          if (out_port_o !== e.port || warming_up_o !== e.warm || link_cost_o !== e.cost ||
              band_o !== e.band || report_o !== e.rep) begin
            $display("%0t: mismatch expected port=%0d warm=%0d cost=%0d band=%0d rep=%0d",
                     $realtime, e.port, e.warm, e.cost, e.band, e.rep);
            $display("%0t:          actual   port=%0d warm=%0d cost=%0d band=%0d rep=%0d",
                     $realtime, out_port_o, warming_up_o, link_cost_o, band_o, report_o);
            errors++;
          end
        end
        stall_left = no_gaps ? 0 : $urandom_range(0, 10);
        out_stall_i <= (stall_left != 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= (stall_left != 0);
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
      $display("link_congestion_cost_monitor_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    capacity     = lcc_pkg::CAP_RST;
    weight       = lcc_pkg::WGT_RST;
    base         = lcc_pkg::BASE_RST;
    band_lims[0] = lcc_pkg::BAND0_RST;
    band_lims[1] = lcc_pkg::BAND1_RST;
    band_lims[2] = lcc_pkg::BAND2_RST;
    band_lims[3] = lcc_pkg::BAND3_RST;
    for (int p = 0; p < NPORT; p++) begin
      last_cnt[p]  = '0;
      delta_sum[p] = '0;
      slot_ptr[p]  = 0;
      fill_cnt[p]  = 0;
      cur_band[p]  = 0;
      walk_lvl[p]  = 64'($urandom >> 8);
      for (int w = 0; w < NWIN; w++) deltas[p][w] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_warmup_and_wrap();
    test_band_walk();
    test_reg_extremes();
    for (int ph = 0; ph < 10; ph++) test_random_phase(80);

    repeat (20) @(posedge clk_i);
    $display("Covered %0d samples, %0d results checked, %0d evaluated, %0d band moves.",
             n_sent, n_checked, n_evals, n_moves);
    $display("Register settings included zero and full capacity, weight, base and limits.");
    if (errors == 0 && pending_costs.size() == 0) begin
      $display("link_congestion_cost_monitor_top_tb: PASS");
    end else begin
      $display("link_congestion_cost_monitor_top_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lcc_pkg.sv
rtl/core/lcc_div.sv
rtl/core/link_congestion_cost_monitor_top.sv
bench/link_congestion_cost_monitor_top_tb.sv
